// ----- rtl/tfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfc_pkg
// shared types and constants for the telemetry frame checker
// ----------------------------------------------------------------------------
package tfc_pkg;

   // request kinds
   typedef enum logic [0:0] {
      FUNC_BYTE = 1'b0,
      FUNC_GAP  = 1'b1
   } func_type;

   // frame verdicts
   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   localparam int COUNT_W   = 5;
   localparam int COUNT_MAX = 31;
   localparam int SUM_BYTES = 18;

   localparam logic [8:0] FLETCHER_MOD = 9'd255;

   // byte offsets of the captured words inside a frame
   localparam logic [COUNT_W-1:0] POS_VOLT_LO  = 5'd0;
   localparam logic [COUNT_W-1:0] POS_VOLT_HI  = 5'd1;
   localparam logic [COUNT_W-1:0] POS_TEMP_LO  = 5'd2;
   localparam logic [COUNT_W-1:0] POS_TEMP_HI  = 5'd3;
   localparam logic [COUNT_W-1:0] POS_CURR_LO  = 5'd4;
   localparam logic [COUNT_W-1:0] POS_CURR_HI  = 5'd5;
   localparam logic [COUNT_W-1:0] POS_RPM_B0   = 5'd8;
   localparam logic [COUNT_W-1:0] POS_RPM_B1   = 5'd9;
   localparam logic [COUNT_W-1:0] POS_RPM_B2   = 5'd10;
   localparam logic [COUNT_W-1:0] POS_RPM_B3   = 5'd11;
   localparam logic [COUNT_W-1:0] POS_CHECK_LO = 5'd18;
   localparam logic [COUNT_W-1:0] POS_CHECK_HI = 5'd19;

   // add two residues mod 255; operands stay below 256 so one subtract suffices
   function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= FLETCHER_MOD) begin
         s = s - FLETCHER_MOD;
      end
      return s[7:0];
   endfunction

endpackage

// ----- rtl/telemetry_frame_checker.sv -----
// ----------------------------------------------------------------------------
// telemetry_frame_checker
// byte-wise frame checker: count, fletcher-16 sums, raw word capture, verdict
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall req_func, req_rx_byte
//   rsp_      out        rsp_valid/rsp_stall rsp_status, rsp_*_raw
//
// one item per cycle while req_stall is low: a data byte updates the frame
// state in the cycle it is accepted, a gap item loads the result register the
// same cycle and the result shows on rsp_ in the next cycle.
// req_stall is raised only while a result sits in the result register and
// the consumer stalls it; a draining result frees the slot in the same cycle.
// synchronous active-high reset clears the frame state and the result valid.
// a gap with no bytes gives no result and leaves the state clear.
//
module telemetry_frame_checker #(
   parameter int FRAME_BYTES = 22
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_voltage_raw,
   output logic [15:0] rsp_temperature_raw,
   output logic [15:0] rsp_current_raw,
   output logic [31:0] rsp_rpm_raw
);

   localparam int CW = tfc_pkg::COUNT_W;
   // count saturates one past the frame length, capped by the counter width
   localparam int COUNT_LIMIT_I = (FRAME_BYTES + 1 > tfc_pkg::COUNT_MAX) ?
                                  tfc_pkg::COUNT_MAX : FRAME_BYTES + 1;
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(COUNT_LIMIT_I);
   localparam logic [CW-1:0] FRAME_LEN   = CW'(FRAME_BYTES);
   localparam logic [CW-1:0] SUM_LEN     = CW'(tfc_pkg::SUM_BYTES);

   // frame state
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    sum_lo_ff, sum_lo_in;
   logic [7:0]    sum_hi_ff, sum_hi_in;
   logic [15:0]   check_ff, check_in;
   logic [15:0]   volt_ff, volt_in;
   logic [15:0]   temp_ff, temp_in;
   logic [15:0]   curr_ff, curr_in;
   logic [31:0]   rpm_ff, rpm_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   tfc_pkg::status_type status_ff, status_in;
   logic [15:0]   out_volt_ff, out_temp_ff, out_curr_ff;
   logic [31:0]   out_rpm_ff;

   logic          req_take;
   logic          is_gap;
   logic          rsp_free;
   logic          emit;
   logic [7:0]    lo_next;

   // result slot is free when empty or being drained this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !rsp_free;
   assign req_take  = req_valid && rsp_free;
   assign is_gap    = (tfc_pkg::func_type'(req_func) == tfc_pkg::FUNC_GAP);
   // a gap ending a nonempty frame produces a result
   assign emit      = req_take && is_gap && (count_ff != '0);

   assign lo_next = tfc_pkg::mod255_add(sum_lo_ff, req_rx_byte);

   // frame state update
   always_comb begin
      count_in  = count_ff;
      sum_lo_in = sum_lo_ff;
      sum_hi_in = sum_hi_ff;
      check_in  = check_ff;
      volt_in   = volt_ff;
      temp_in   = temp_ff;
      curr_in   = curr_ff;
      rpm_in    = rpm_ff;
      if (req_take && is_gap) begin
         // any gap clears the frame
         count_in  = '0;
         sum_lo_in = '0;
         sum_hi_in = '0;
         check_in  = '0;
         volt_in   = '0;
         temp_in   = '0;
         curr_in   = '0;
         rpm_in    = '0;
      end else if (req_take && (count_ff < COUNT_LIMIT)) begin
         count_in = count_ff + CW'(1);
         // only the leading bytes feed the sums
         if (count_ff < SUM_LEN) begin
            sum_lo_in = lo_next;
            sum_hi_in = tfc_pkg::mod255_add(sum_hi_ff, lo_next);
         end
         // little-endian word capture by byte position
         unique case (count_ff)
            tfc_pkg::POS_VOLT_LO:  volt_in[7:0]    = req_rx_byte;
            tfc_pkg::POS_VOLT_HI:  volt_in[15:8]   = req_rx_byte;
            tfc_pkg::POS_TEMP_LO:  temp_in[7:0]    = req_rx_byte;
            tfc_pkg::POS_TEMP_HI:  temp_in[15:8]   = req_rx_byte;
            tfc_pkg::POS_CURR_LO:  curr_in[7:0]    = req_rx_byte;
            tfc_pkg::POS_CURR_HI:  curr_in[15:8]   = req_rx_byte;
            tfc_pkg::POS_RPM_B0:   rpm_in[7:0]     = req_rx_byte;
            tfc_pkg::POS_RPM_B1:   rpm_in[15:8]    = req_rx_byte;
            tfc_pkg::POS_RPM_B2:   rpm_in[23:16]   = req_rx_byte;
            tfc_pkg::POS_RPM_B3:   rpm_in[31:24]   = req_rx_byte;
            tfc_pkg::POS_CHECK_LO: check_in[7:0]   = req_rx_byte;
            tfc_pkg::POS_CHECK_HI: check_in[15:8]  = req_rx_byte;
            default: ;
         endcase
      end
   end

   // verdict: length first, then checksum compare
   always_comb begin
      priority if (count_ff != FRAME_LEN) begin
         status_in = tfc_pkg::STATUS_LENGTH;
      end else if ({sum_hi_ff, sum_lo_ff} == check_ff) begin
         status_in = tfc_pkg::STATUS_GOOD;
      end else begin
         status_in = tfc_pkg::STATUS_MISMATCH;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_lo_ff    <= '0;
         sum_hi_ff    <= '0;
         check_ff     <= '0;
         volt_ff      <= '0;
         temp_ff      <= '0;
         curr_ff      <= '0;
         rpm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_lo_ff    <= sum_lo_in;
         sum_hi_ff    <= sum_hi_in;
         check_ff     <= check_in;
         volt_ff      <= volt_in;
         temp_ff      <= temp_in;
         curr_ff      <= curr_in;
         rpm_ff       <= rpm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a result is produced
   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff   <= status_in;
         out_volt_ff <= volt_ff;
         out_temp_ff <= temp_ff;
         out_curr_ff <= curr_ff;
         out_rpm_ff  <= rpm_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_voltage_raw     = out_volt_ff;
   assign rsp_temperature_raw = out_temp_ff;
   assign rsp_current_raw     = out_curr_ff;
   assign rsp_rpm_raw         = out_rpm_ff;

   // checks

   // the request side only waits on a stalled, full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("request stalled without a pending result");

   // an accepted gap always leaves the frame state empty
   a_gap_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && is_gap) |=> (count_ff == '0 && sum_lo_ff == '0 && sum_hi_ff == '0))
      else $error("frame state not cleared after gap");

   // a gap after a nonempty frame must present a result next cycle
   a_gap_result: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("gap ending a frame gave no result");

   // the count never passes its saturation limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("byte count past saturation limit");

endmodule
